// File: design/seava_pkg.sv
// seava_pkg: shared types, codes and the built-in sound table of the
// sound event admission and voice allocation block. No dependencies.
`default_nettype none

package seava_pkg;

  localparam int          DEFINED_SOUNDS  = 25;
  localparam int          SPATIAL_BUSY_W  = 24;
  localparam int          LOCAL_BUSY_W    = 6;
  localparam int          CFG_ADDR_W      = 5;
  localparam logic [15:0] QUIET_LIMIT     = 16'd99;
  localparam logic [15:0] UNITY_CALLER    = 16'd16384;
  localparam logic [15:0] GAIN_MAX        = 16'hFFFF;
  localparam logic [15:0] MASTER_GAIN_RST = 16'd40632;
  localparam logic [31:0] LOADED_MASK_RST = 32'h01FF_FFFF;

  typedef enum logic [2:0] {
    REG_ENABLED,
    REG_LISTENER_X,
    REG_LISTENER_Y,
    REG_MASTER_GAIN,
    REG_LOADED_MASK
  } reg_idx_t;

  typedef enum logic [2:0] {
    OC_SPATIAL,
    OC_LOCAL,
    OC_UNKNOWN,
    OC_REJECT,
    OC_THROTTLED,
    OC_RANGE,
    OC_QUIET
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic [4:0]         sound_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               gain_given;
    logic [15:0]        caller_gain;
    logic               force_local;
    logic [31:0]        time_now;
    logic [23:0]        spatial_busy;
    logic [5:0]         local_busy;
  } in_word_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [4:0]  voice_index;
    logic        stole_voice;
    logic [15:0] gain_out;
    logic [15:0] ref_distance;
    logic [15:0] max_distance;
  } out_word_t;

  typedef struct packed {
    logic        enabled;
    logic [15:0] listener_x;
    logic [15:0] listener_y;
    logic [15:0] master_gain;
    logic [31:0] loaded_mask;
  } cfg_t;

  typedef struct packed {
    logic [15:0] ref_dist;
    logic [15:0] max_dist;
    logic [15:0] base_gain;
    logic        local_flag;
    logic [7:0]  gap;
  } snd_entry_t;

  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic mul3;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  function automatic snd_entry_t sound_entry_of(input logic [4:0] idx);
    snd_entry_t e;
    unique case (idx)
      5'd0:  e = '{16'd240, 16'd2000, 16'd32768, 1'b0, 8'd24};
      5'd1:  e = '{16'd300, 16'd2200, 16'd34079, 1'b0, 8'd26};
      5'd2:  e = '{16'd440, 16'd3200, 16'd40632, 1'b0, 8'd50};
      5'd3:  e = '{16'd250, 16'd1800, 16'd24904, 1'b0, 8'd30};
      5'd4:  e = '{16'd320, 16'd2000, 16'd26214, 1'b0, 8'd32};
      5'd5:  e = '{16'd620, 16'd3400, 16'd62259, 1'b0, 8'd12};
      5'd6:  e = '{16'd560, 16'd3000, 16'd58982, 1'b0, 8'd12};
      5'd7:  e = '{16'd430, 16'd2400, 16'd51118, 1'b0, 8'd12};
      5'd8:  e = '{16'd400, 16'd2200, 16'd47186, 1'b0, 8'd12};
      5'd9:  e = '{16'd520, 16'd2800, 16'd55706, 1'b0, 8'd12};
      5'd10: e = '{16'd640, 16'd3600, 16'd65535, 1'b0, 8'd12};
      5'd11: e = '{16'd700, 16'd3800, 16'd65535, 1'b0, 8'd12};
      5'd12: e = '{16'd720, 16'd4200, 16'd65535, 1'b0, 8'd12};
      5'd13: e = '{16'd0,   16'd0,    16'd19661, 1'b1, 8'd40};
      5'd14: e = '{16'd110, 16'd460,  16'd27525, 1'b0, 8'd50};
      5'd15: e = '{16'd170, 16'd950,  16'd19661, 1'b0, 8'd30};
      5'd16: e = '{16'd240, 16'd1300, 16'd22282, 1'b0, 8'd30};
      5'd17: e = '{16'd280, 16'd1500, 16'd22282, 1'b0, 8'd12};
      5'd18: e = '{16'd130, 16'd700,  16'd17039, 1'b0, 8'd45};
      5'd19: e = '{16'd150, 16'd800,  16'd22282, 1'b0, 8'd60};
      5'd20: e = '{16'd210, 16'd1300, 16'd26214, 1'b0, 8'd100};
      5'd21: e = '{16'd0,   16'd0,    16'd22282, 1'b1, 8'd180};
      5'd22: e = '{16'd0,   16'd0,    16'd29491, 1'b1, 8'd12};
      5'd23: e = '{16'd90,  16'd400,  16'd19661, 1'b0, 8'd60};
      5'd24: e = '{16'd90,  16'd400,  16'd20972, 1'b0, 8'd60};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// File: design/seava_cfg.sv
// seava_cfg: apb-style register file for enable, listener position,
// master gain and loaded mask. Depends on seava_pkg.
`default_nettype none

module seava_cfg import seava_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic        enabled_r;
  logic [15:0] listener_x_r;
  logic [15:0] listener_y_r;
  logic [15:0] master_gain_r;
  logic [31:0] loaded_mask_r;
  logic        wr_en;
  reg_idx_t    sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r     <= 1'b1;
      listener_x_r  <= '0;
      listener_y_r  <= '0;
      master_gain_r <= MASTER_GAIN_RST;
      loaded_mask_r <= LOADED_MASK_RST;
    end else if (wr_en) begin
      unique case (sel)
        REG_ENABLED:     enabled_r     <= pwdata[0];
        REG_LISTENER_X:  listener_x_r  <= pwdata[15:0];
        REG_LISTENER_Y:  listener_y_r  <= pwdata[15:0];
        REG_MASTER_GAIN: master_gain_r <= pwdata[15:0];
        REG_LOADED_MASK: loaded_mask_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_ENABLED:     prdata = {31'b0, enabled_r};
      REG_LISTENER_X:  prdata = {16'b0, listener_x_r};
      REG_LISTENER_Y:  prdata = {16'b0, listener_y_r};
      REG_MASTER_GAIN: prdata = {16'b0, master_gain_r};
      REG_LOADED_MASK: prdata = loaded_mask_r;
      default:         prdata = '0;
    endcase
  end

  assign cfg = '{enabled:     enabled_r,
                 listener_x:  listener_x_r,
                 listener_y:  listener_y_r,
                 master_gain: master_gain_r,
                 loaded_mask: loaded_mask_r};

endmodule

`default_nettype wire

// File: design/seava_ctrl.sv
// seava_ctrl: sequencer that walks one event through capture, three
// multiply steps and the decision. Depends on seava_pkg.
`default_nettype none

module seava_ctrl import seava_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        // hold here while the previous result is still stalled
        cmd.commit = status.out_free;
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: design/seava_dp.sv
// seava_dp: admission checks, gain and distance multipliers, round-robin
// voice pick, last-play memory and the output register. Depends on seava_pkg.
`default_nettype none

module seava_dp import seava_pkg::*; #(
  parameter int SPATIAL_VOICES = 24,
  parameter int LOCAL_VOICES   = 6,
  parameter int SOUND_SLOTS    = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  input  cfg_t       cfg,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data
);

  localparam int IDX_W   = (SOUND_SLOTS > 1) ? $clog2(SOUND_SLOTS) : 1;
  localparam int SP_W    = (SPATIAL_VOICES > 1) ? $clog2(SPATIAL_VOICES) : 1;
  localparam int LP_W    = (LOCAL_VOICES > 1) ? $clog2(LOCAL_VOICES) : 1;
  localparam int DEF_CNT = (SOUND_SLOTS < DEFINED_SOUNDS) ? SOUND_SLOTS : DEFINED_SOUNDS;
  localparam logic [4:0]  DEF_CNT_V = 5'(DEF_CNT);
  localparam logic [31:0] DEF_MASK  = (32'd1 << DEF_CNT) - 32'd1;
  localparam logic [SP_W:0] SP_N = (SP_W + 1)'(SPATIAL_VOICES);
  localparam logic [LP_W:0] LP_N = (LP_W + 1)'(LOCAL_VOICES);

  // captured event and per-sound data
  in_word_t   in_r;
  snd_entry_t ent_r;
  logic       early_r;
  outcome_t   early_code_r;
  logic       local_play_r;
  logic [15:0] adx_r;
  logic [15:0] ady_r;
  logic [31:0] last_rd_r;
  logic        seen_r;

  // multiply pipeline
  logic [31:0] p1_r;
  logic [31:0] sqx_r;
  logic [31:0] sqy_r;
  logic [47:0] g48_r;
  logic [31:0] m2_r;
  logic [32:0] d2_r;
  logic [15:0] gain_r;
  logic        thr_r;

  logic [31:0] last_mem [SOUND_SLOTS];
  logic [SOUND_SLOTS-1:0] played_r;
  logic [SP_W-1:0] sp_ptr_r;
  logic [SP_W-1:0] sp_ptr_nxt;
  logic [LP_W-1:0] lp_ptr_r;
  logic [LP_W-1:0] lp_ptr_nxt;
  logic            out_valid_r;
  out_word_t       out_data_r;

  snd_entry_t  ent_lk;
  logic        early_c;
  outcome_t    early_code_c;
  logic [16:0] dx_c;
  logic [16:0] dy_c;
  logic [15:0] caller_eff;
  logic [IDX_W-1:0] cap_idx;
  logic [IDX_W-1:0] run_idx;

  logic [SP_W-1:0] sp_pick;
  logic            sp_found;
  logic [LP_W-1:0] lp_pick;
  logic            lp_found;
  logic            hit;
  out_word_t       res;

  assign cap_idx = in_data.sound_index[IDX_W-1:0];
  assign run_idx = in_r.sound_index[IDX_W-1:0];
  assign ent_lk  = sound_entry_of(in_data.sound_index);

  always_comb begin
    early_c      = 1'b1;
    early_code_c = OC_REJECT;
    priority if (!cfg.enabled || (cfg.loaded_mask & DEF_MASK) == '0) begin
      early_code_c = OC_REJECT;
    end else if (in_data.sound_index >= DEF_CNT_V) begin
      early_code_c = OC_UNKNOWN;
    end else if (!cfg.loaded_mask[in_data.sound_index]) begin
      early_code_c = OC_REJECT;
    end else begin
      early_c = 1'b0;
    end
  end

  assign dx_c = {in_data.pos_x[15], in_data.pos_x} - {cfg.listener_x[15], cfg.listener_x};
  assign dy_c = {in_data.pos_y[15], in_data.pos_y} - {cfg.listener_y[15], cfg.listener_y};
  assign caller_eff = in_r.gain_given ? in_r.caller_gain : UNITY_CALLER;

  // last play time memory, registered read at capture
  always_ff @(posedge clk) begin
    if (cmd.capture) last_rd_r <= last_mem[cap_idx];
    if (cmd.commit && hit) last_mem[run_idx] <= in_r.time_now;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r         <= in_data;
      ent_r        <= ent_lk;
      early_r      <= early_c;
      early_code_r <= early_code_c;
      local_play_r <= in_data.force_local || ent_lk.local_flag || ent_lk.ref_dist == '0;
      adx_r        <= dx_c[16] ? 16'(-dx_c) : dx_c[15:0];
      ady_r        <= dy_c[16] ? 16'(-dy_c) : dy_c[15:0];
      seen_r       <= (32'(in_data.sound_index) < 32'(SOUND_SLOTS)) ? played_r[cap_idx] : 1'b0;
    end
    if (cmd.mul1) begin
      p1_r  <= {16'b0, ent_r.base_gain} * {16'b0, caller_eff};
      sqx_r <= {16'b0, adx_r} * {16'b0, adx_r};
      // elapsed time wraps modulo 2^32
      thr_r <= seen_r && ((in_r.time_now - last_rd_r) < {24'b0, ent_r.gap});
    end
    if (cmd.mul2) begin
      g48_r <= {16'b0, p1_r} * {32'b0, cfg.master_gain};
      sqy_r <= {16'b0, ady_r} * {16'b0, ady_r};
    end
    if (cmd.mul3) begin
      m2_r   <= {16'b0, ent_r.max_dist} * {16'b0, ent_r.max_dist};
      d2_r   <= {1'b0, sqx_r} + {1'b0, sqy_r};
      gain_r <= (g48_r[47:46] != 2'b0) ? GAIN_MAX : g48_r[45:30];
    end
  end

  // spatial pick: first idle voice at or after the pointer
  always_comb begin
    logic [SP_W:0] pos;
    sp_found = 1'b0;
    sp_pick  = sp_ptr_r;
    for (int i = SPATIAL_VOICES - 1; i >= 0; i--) begin
      pos = {1'b0, sp_ptr_r} + (SP_W + 1)'(i);
      if (pos >= SP_N) pos = pos - SP_N;
      if ((32'(pos) >= 32'(SPATIAL_BUSY_W)) || !in_r.spatial_busy[pos[SP_W-1:0]]) begin
        sp_found = 1'b1;
        sp_pick  = pos[SP_W-1:0];
      end
    end
  end

  always_comb begin
    logic [LP_W:0] pos;
    lp_found = 1'b0;
    lp_pick  = lp_ptr_r;
    for (int i = LOCAL_VOICES - 1; i >= 0; i--) begin
      pos = {1'b0, lp_ptr_r} + (LP_W + 1)'(i);
      if (pos >= LP_N) pos = pos - LP_N;
      if ((32'(pos) >= 32'(LOCAL_BUSY_W)) || !in_r.local_busy[pos[LP_W-1:0]]) begin
        lp_found = 1'b1;
        lp_pick  = pos[LP_W-1:0];
      end
    end
  end

  // decision and pointer advance
  always_comb begin
    logic [SP_W:0] sp_inc;
    logic [LP_W:0] lp_inc;
    res        = '0;
    res.outcome = OC_REJECT;
    hit        = 1'b0;
    sp_ptr_nxt = sp_ptr_r;
    lp_ptr_nxt = lp_ptr_r;
    sp_inc     = {1'b0, sp_pick} + 1'b1;
    lp_inc     = {1'b0, lp_pick} + 1'b1;
    if (sp_inc == SP_N) sp_inc = '0;
    if (lp_inc == LP_N) lp_inc = '0;
    priority if (early_r) begin
      res.outcome = early_code_r;
    end else if (thr_r) begin
      res.outcome = OC_THROTTLED;
    end else begin
      hit = 1'b1;
      priority if (!local_play_r && d2_r > {1'b0, m2_r}) begin
        res.outcome = OC_RANGE;
      end else if (gain_r < QUIET_LIMIT) begin
        res.outcome = OC_QUIET;
      end else if (local_play_r) begin
        res.outcome     = OC_LOCAL;
        res.voice_index = 5'(lp_pick);
        res.stole_voice = !lp_found;
        res.gain_out    = gain_r;
        lp_ptr_nxt      = lp_inc[LP_W-1:0];
      end else begin
        res.outcome      = OC_SPATIAL;
        res.voice_index  = 5'(sp_pick);
        res.stole_voice  = !sp_found;
        res.gain_out     = gain_r;
        res.ref_distance = ent_r.ref_dist;
        res.max_distance = ent_r.max_dist;
        sp_ptr_nxt       = sp_inc[SP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      played_r    <= '0;
      sp_ptr_r    <= '0;
      lp_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        sp_ptr_r    <= sp_ptr_nxt;
        lp_ptr_r    <= lp_ptr_nxt;
        out_valid_r <= 1'b1;
        if (hit) played_r[run_idx] <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_data_r <= res;
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

`default_nettype wire

// File: design/sound_event_admit_voice_alloc.sv
// sound_event_admit_voice_alloc: one word in, one word out. The result word
// is registered after capture, three multiply steps and the decision; a new
// word is taken only after the last one has left the decision. A stalled
// result delays the decision step only. Synchronous active-low reset clears
// config, pointers and play history; the last-play memory is not cleared and
// needs no clearing pass.
`default_nettype none

module sound_event_admit_voice_alloc import seava_pkg::*; #(
  parameter int SPATIAL_VOICES = 24,
  parameter int LOCAL_VOICES   = 6,
  parameter int SOUND_SLOTS    = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  seava_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  seava_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  seava_dp #(
    .SPATIAL_VOICES (SPATIAL_VOICES),
    .LOCAL_VOICES   (LOCAL_VOICES),
    .SOUND_SLOTS    (SOUND_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg       (cfg),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: design/seava_chk.sv
// seava_chk: port-level assertions for sound_event_admit_voice_alloc,
// attached by bind. Depends on seava_pkg.
`default_nettype none

module seava_chk import seava_pkg::*; #(
  parameter int SPATIAL_VOICES = 24,
  parameter int LOCAL_VOICES   = 6
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  logic in_take;
  assign in_take = in_valid && !in_stall;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one event at a time
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_stall)
    else $error("input taken while an event is in flight");

  // with the result register draining, the decision never waits
  a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && !(out_valid && out_stall) |-> ##5 out_valid)
    else $error("no result word five cycles after input");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome != OC_SPATIAL && out_data.outcome != OC_LOCAL
    |-> out_data.voice_index == '0 && !out_data.stole_voice && out_data.gain_out == '0
        && out_data.ref_distance == '0 && out_data.max_distance == '0)
    else $error("rejected word carries nonzero fields");

  a_played_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.outcome == OC_SPATIAL || out_data.outcome == OC_LOCAL)
    |-> out_data.gain_out >= QUIET_LIMIT
        && ((out_data.outcome == OC_LOCAL && 32'(out_data.voice_index) < LOCAL_VOICES
             && out_data.ref_distance == '0 && out_data.max_distance == '0)
            || (out_data.outcome == OC_SPATIAL
                && 32'(out_data.voice_index) < SPATIAL_VOICES)))
    else $error("played word has bad voice, gain or distances");

endmodule

bind sound_event_admit_voice_alloc seava_chk #(
  .SPATIAL_VOICES (SPATIAL_VOICES),
  .LOCAL_VOICES   (LOCAL_VOICES)
) u_seava_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: sim/sound_event_admit_voice_alloc_test.sv
// Self-checking bench for sound_event_admit_voice_alloc: a local predictor of event
// admission, gain and round-robin voice choice is checked against every result word.
// Depends on seava_pkg and the block's RTL only.
`timescale 1ns / 100ps

module sound_event_admit_voice_alloc_test import seava_pkg::*;;

  localparam int          SPATIAL_N   = 24;
  localparam int          LOCAL_N     = 6;
  localparam logic [31:0] DEFINED_BITS = (32'd1 << DEFINED_SOUNDS) - 32'd1;
  localparam int          CYCLE_LIMIT = 200000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // predictor copy of registers and play history
  logic               cfg_enabled = 1'b1;
  logic signed [15:0] cfg_lx = '0;
  logic signed [15:0] cfg_ly = '0;
  logic [15:0]        cfg_master = MASTER_GAIN_RST;
  logic [31:0]        cfg_loaded = LOADED_MASK_RST;
  snd_entry_t         sound_tab [DEFINED_SOUNDS];
  logic [31:0]        last_time [32];
  logic [31:0]        played_mask = '0;
  int                 spatial_ptr = 0;
  int                 local_ptr = 0;

  out_word_t pending_outcomes [$];
  int        fail_count = 0;
  int        cycle_count = 0;
  int        hold_left = 0;
  logic      no_idle = 1'b0;
  logic [31:0] now_ms = 32'd5000;
  logic [4:0]  last_idx = '0;

  sound_event_admit_voice_alloc dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    sound_tab[0]  = {16'd240, 16'd2000, 16'd32768, 1'b0, 8'd24};
    sound_tab[1]  = {16'd300, 16'd2200, 16'd34079, 1'b0, 8'd26};
    sound_tab[2]  = {16'd440, 16'd3200, 16'd40632, 1'b0, 8'd50};
    sound_tab[3]  = {16'd250, 16'd1800, 16'd24904, 1'b0, 8'd30};
    sound_tab[4]  = {16'd320, 16'd2000, 16'd26214, 1'b0, 8'd32};
    sound_tab[5]  = {16'd620, 16'd3400, 16'd62259, 1'b0, 8'd12};
    sound_tab[6]  = {16'd560, 16'd3000, 16'd58982, 1'b0, 8'd12};
    sound_tab[7]  = {16'd430, 16'd2400, 16'd51118, 1'b0, 8'd12};
    sound_tab[8]  = {16'd400, 16'd2200, 16'd47186, 1'b0, 8'd12};
    sound_tab[9]  = {16'd520, 16'd2800, 16'd55706, 1'b0, 8'd12};
    sound_tab[10] = {16'd640, 16'd3600, 16'd65535, 1'b0, 8'd12};
    sound_tab[11] = {16'd700, 16'd3800, 16'd65535, 1'b0, 8'd12};
    sound_tab[12] = {16'd720, 16'd4200, 16'd65535, 1'b0, 8'd12};
    sound_tab[13] = {16'd0,   16'd0,    16'd19661, 1'b1, 8'd40};
    sound_tab[14] = {16'd110, 16'd460,  16'd27525, 1'b0, 8'd50};
    sound_tab[15] = {16'd170, 16'd950,  16'd19661, 1'b0, 8'd30};
    sound_tab[16] = {16'd240, 16'd1300, 16'd22282, 1'b0, 8'd30};
    sound_tab[17] = {16'd280, 16'd1500, 16'd22282, 1'b0, 8'd12};
    sound_tab[18] = {16'd130, 16'd700,  16'd17039, 1'b0, 8'd45};
    sound_tab[19] = {16'd150, 16'd800,  16'd22282, 1'b0, 8'd60};
    sound_tab[20] = {16'd210, 16'd1300, 16'd26214, 1'b0, 8'd100};
    sound_tab[21] = {16'd0,   16'd0,    16'd22282, 1'b1, 8'd180};
    sound_tab[22] = {16'd0,   16'd0,    16'd29491, 1'b1, 8'd12};
    sound_tab[23] = {16'd90,  16'd400,  16'd19661, 1'b0, 8'd60};
    sound_tab[24] = {16'd90,  16'd400,  16'd20972, 1'b0, 8'd60};
  end

  // first idle voice at or after the pointer, else steal the one under it
  function automatic int choose_voice(inout int ptr, input int n, input logic [31:0] busy,
                                      output logic took);
    int k;
    int voice;
    took  = 1'b1;
    voice = ptr % n;
    for (int i = 0; i < n && took; i++) begin
      k = (ptr + i) % n;
      if (!busy[k]) begin
        voice = k;
        took  = 1'b0;
      end
    end
    ptr = (voice + 1) % n;
    return voice;
  endfunction

  function automatic out_word_t predict_admission(in_word_t w);
    out_word_t   r;
    snd_entry_t  e;
    logic [47:0] prod;
    logic [15:0] caller;
    logic [15:0] g;
    logic [31:0] elapsed;
    longint      dx, dy, d2, m2;
    logic        is_loc;
    logic        took;
    int          idx;
    r   = '0;
    idx = int'(w.sound_index);
    if (!cfg_enabled || (cfg_loaded & DEFINED_BITS) == 32'd0) begin
      r.outcome = OC_REJECT;
      return r;
    end
    if (idx >= DEFINED_SOUNDS) begin
      r.outcome = OC_UNKNOWN;
      return r;
    end
    if (!cfg_loaded[idx]) begin
      r.outcome = OC_REJECT;
      return r;
    end
    e       = sound_tab[idx];
    is_loc  = w.force_local || e.local_flag || e.ref_dist == 16'd0;
    elapsed = w.time_now - last_time[idx];
    if (played_mask[idx] && elapsed < 32'(e.gap)) begin
      r.outcome = OC_THROTTLED;
      return r;
    end
    // history moves even if the event is dropped further down
    last_time[idx]   = w.time_now;
    played_mask[idx] = 1'b1;
    caller = w.gain_given ? w.caller_gain : UNITY_CALLER;
    prod   = 48'(e.base_gain) * 48'(caller) * 48'(cfg_master);
    g      = (prod[47:46] != 2'b00) ? GAIN_MAX : prod[45:30];
    if (!is_loc) begin
      dx = longint'($signed(w.pos_x)) - longint'(cfg_lx);
      dy = longint'($signed(w.pos_y)) - longint'(cfg_ly);
      d2 = dx * dx + dy * dy;
      m2 = longint'(e.max_dist) * longint'(e.max_dist);
      if (d2 > m2) begin
        r.outcome = OC_RANGE;
        return r;
      end
    end
    if (g < QUIET_LIMIT) begin
      r.outcome = OC_QUIET;
      return r;
    end
    if (is_loc) begin
      r.voice_index = 5'(choose_voice(local_ptr, LOCAL_N, 32'(w.local_busy), took));
      r.outcome     = OC_LOCAL;
    end else begin
      r.voice_index  = 5'(choose_voice(spatial_ptr, SPATIAL_N, 32'(w.spatial_busy), took));
      r.outcome      = OC_SPATIAL;
      r.ref_distance = e.ref_dist;
      r.max_distance = e.max_dist;
    end
    r.stole_voice = took;
    r.gain_out    = g;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        $error("result word with nothing expected: %h", out_data);
      end else begin
        want = pending_outcomes.pop_front();
        check_field("outcome", want.outcome, out_data.outcome);
        check_field("voice_index", want.voice_index, out_data.voice_index);
        check_field("stole_voice", want.stole_voice, out_data.stole_voice);
        check_field("gain_out", want.gain_out, out_data.gain_out);
        check_field("ref_distance", want.ref_distance, out_data.ref_distance);
        check_field("max_distance", want.max_distance, out_data.max_distance);
      end
    end
  end

  // result side: random stall, or a counted hold-off when asked for
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = !no_idle && ($urandom_range(99) < 32);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_event(in_word_t w);
    logic [127:0] noise;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 32) begin
      noise    = {$urandom, $urandom, $urandom, $urandom};
      in_valid = 1'b0;
      in_data  = noise[$bits(in_word_t)-1:0];
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (in_stall);
    pending_outcomes = {pending_outcomes, predict_admission(w)};
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t r, logic [31:0] v);
    drain();
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {r, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_ENABLED:     cfg_enabled = v[0];
      REG_LISTENER_X:  cfg_lx      = v[15:0];
      REG_LISTENER_Y:  cfg_ly      = v[15:0];
      REG_MASTER_GAIN: cfg_master  = v[15:0];
      REG_LOADED_MASK: cfg_loaded  = v;
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic in_word_t directed_word(logic [4:0] idx, logic [15:0] x, logic [15:0] y,
                                             logic [15:0] cg, logic [31:0] t);
    in_word_t w;
    w             = '0;
    w.sound_index = idx;
    w.pos_x       = x;
    w.pos_y       = y;
    w.gain_given  = 1'b1;
    w.caller_gain = cg;
    w.time_now    = t;
    return w;
  endfunction

  // events biased toward admission, repeats of one sound and busy pools
  function automatic in_word_t rand_event();
    in_word_t w;
    int       dice;
    w    = '0;
    dice = $urandom_range(99);
    if (dice < 30)
      w.sound_index = last_idx;
    else if (dice < 88)
      w.sound_index = 5'($urandom_range(DEFINED_SOUNDS - 1));
    else
      w.sound_index = 5'($urandom_range(31, DEFINED_SOUNDS));
    last_idx = w.sound_index;

    dice = $urandom_range(99);
    if (dice < 4)
      now_ms = $urandom;
    else if (dice < 40)
      now_ms = now_ms + 32'($urandom_range(20));
    else
      now_ms = now_ms + 32'($urandom_range(200));
    w.time_now = now_ms;

    if ($urandom_range(99) < 75) begin
      w.pos_x = cfg_lx + 16'(int'($urandom_range(6000)) - 3000);
      w.pos_y = cfg_ly + 16'(int'($urandom_range(6000)) - 3000);
    end else begin
      w.pos_x = 16'($urandom);
      w.pos_y = 16'($urandom);
    end

    w.gain_given = ($urandom_range(99) < 80);
    dice = $urandom_range(99);
    if (dice < 50)
      w.caller_gain = 16'($urandom_range(30000, 8000));
    else if (dice < 70)
      w.caller_gain = 16'($urandom);
    else if (dice < 85)
      w.caller_gain = 16'($urandom_range(200));
    else
      w.caller_gain = 16'($urandom_range(65535, 50000));
    w.force_local = ($urandom_range(99) < 20);

    case ($urandom_range(3))
      0:       w.spatial_busy = 24'($urandom);
      1:       w.spatial_busy = '1;
      2:       w.spatial_busy = ~(24'd1 << $urandom_range(SPATIAL_N - 1));
      default: w.spatial_busy = 24'($urandom & $urandom & $urandom);
    endcase
    case ($urandom_range(3))
      0:       w.local_busy = 6'($urandom);
      1:       w.local_busy = '1;
      2:       w.local_busy = ~(6'd1 << $urandom_range(LOCAL_N - 1));
      default: w.local_busy = 6'($urandom & $urandom);
    endcase
    return w;
  endfunction

  task automatic run_events(int n);
    repeat (n) send_event(rand_event());
  endtask

  task automatic test_directed_cases();
    in_word_t w;
    send_event(directed_word(5'd0, 16'd0, 16'd0, 16'd16384, 32'd1000));
    send_event(directed_word(5'd0, 16'd0, 16'd0, 16'd16384, 32'd1000));
    send_event(directed_word(5'd0, 16'd0, 16'd0, 16'd16384, 32'd1023));
    // exactly the gap later is allowed
    send_event(directed_word(5'd0, 16'd0, 16'd0, 16'd16384, 32'd1024));
    send_event(directed_word(5'd13, 16'd0, 16'd0, 16'd16384, 32'd1000));
    w = directed_word(5'd1, 16'h7FFF, 16'h7FFF, 16'd16384, 32'd1000);
    w.force_local = 1'b1;
    send_event(w);
    send_event(directed_word(5'd25, 16'd0, 16'd0, 16'd16384, 32'd1000));
    send_event(directed_word(5'd31, 16'd0, 16'd0, 16'd16384, 32'd1000));
    send_event(directed_word(5'd2, 16'h7FFF, 16'h8000, 16'd16384, 32'd1000));
    send_event(directed_word(5'd3, 16'd1800, 16'd0, 16'd16384, 32'd1000));
    send_event(directed_word(5'd4, 16'd2000, 16'd1, 16'd16384, 32'd1000));
    send_event(directed_word(5'd4, 16'd0, 16'd0, 16'd16384, 32'd1001));
    send_event(directed_word(5'd5, 16'd0, 16'd0, 16'd0, 32'd1000));
    send_event(directed_word(5'd5, 16'd0, 16'd0, 16'd16384, 32'd1005));
    send_event(directed_word(5'd10, 16'd10, 16'd10, 16'hFFFF, 32'd1000));
    w = directed_word(5'd11, 16'd0, 16'd0, 16'd16384, 32'd1000);
    w.spatial_busy = '1;
    send_event(w);
    w = directed_word(5'd22, 16'd0, 16'd0, 16'd16384, 32'd1000);
    w.local_busy = '1;
    send_event(w);
    // time wraps, then runs backwards
    send_event(directed_word(5'd6, 16'd0, 16'd0, 16'd16384, 32'hFFFF_FFF0));
    send_event(directed_word(5'd6, 16'd0, 16'd0, 16'd16384, 32'd5));
    send_event(directed_word(5'd6, 16'd0, 16'd0, 16'd16384, 32'd3));
    w = directed_word(5'd7, 16'd0, 16'd0, 16'd0, 32'd1000);
    w.gain_given = 1'b0;
    send_event(w);
    send_event(directed_word(5'd8, 16'h8000, 16'h8000, 16'd16384, 32'd1000));
    w = directed_word(5'd24, 16'hFFA0, 16'd60, 16'd16384, 32'd1000);
    w.spatial_busy = 24'hFF_FFFE;
    send_event(w);
    drain();
  endtask

  task automatic test_register_settings();
    write_register(REG_ENABLED, 32'd0);
    run_events(40);
    write_register(REG_ENABLED, 32'hFFFF_FFFF);
    write_register(REG_LISTENER_X, 32'h0000_7FFF);
    write_register(REG_LISTENER_Y, 32'hFFFF_8000);
    run_events(40);
    write_register(REG_LISTENER_X, 32'h0000_8000);
    write_register(REG_LISTENER_Y, 32'h0000_7FFF);
    run_events(40);
    write_register(REG_MASTER_GAIN, 32'd0);
    run_events(30);
    write_register(REG_MASTER_GAIN, 32'h0000_FFFF);
    write_register(REG_LISTENER_X, 32'($urandom));
    write_register(REG_LISTENER_Y, 32'($urandom));
    run_events(40);
    write_register(REG_LOADED_MASK, 32'd0);
    run_events(30);
    // only slots past the defined sounds: counts as nothing loaded
    write_register(REG_LOADED_MASK, ~DEFINED_BITS);
    run_events(30);
    write_register(REG_LOADED_MASK, $urandom);
    run_events(40);
    write_register(REG_LOADED_MASK, 32'hFFFF_FFFF);
    write_register(REG_MASTER_GAIN, 32'($urandom_range(65535)));
    run_events(40);
    write_register(REG_LISTENER_X, 32'd0);
    write_register(REG_LISTENER_Y, 32'd0);
    write_register(REG_MASTER_GAIN, 32'(MASTER_GAIN_RST));
    write_register(REG_LOADED_MASK, LOADED_MASK_RST);
  endtask

  task automatic test_output_backpressure();
    drain();
    hold_left = 300;
    no_idle   = 1'b1;
    run_events(40);
    no_idle   = 1'b0;
    drain();
  endtask

  task automatic test_sender_pause();
    repeat (6) begin
      run_events($urandom_range(8, 1));
      drain();
    end
  endtask

  task automatic test_random_traffic();
    for (int blk = 0; blk < 8; blk++) begin
      if (blk > 0) begin
        write_register(REG_LISTENER_X, 32'(int'($urandom_range(4000)) - 2000));
        write_register(REG_LISTENER_Y, 32'(int'($urandom_range(4000)) - 2000));
        write_register(REG_MASTER_GAIN, 32'($urandom_range(65535, 20000)));
        write_register(REG_LOADED_MASK,
                       ($urandom_range(3) == 0) ? $urandom : 32'hFFFF_FFFF);
      end
      no_idle = (blk == 3);
      run_events(140);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_cases();
    test_register_settings();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic();
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
design/seava_pkg.sv
design/seava_cfg.sv
design/seava_ctrl.sv
design/seava_dp.sv
design/sound_event_admit_voice_alloc.sv
design/seava_chk.sv
sim/sound_event_admit_voice_alloc_test.sv
